/* hw/rtl/edc_pkg.sv */
// Shared types and constants for the error count distribution block.
// No dependencies; imported by every module of the block.
package edc_pkg;

	localparam int PROB_W         = 17;
	localparam int PROB_FRAC      = 16;
	localparam int COEF_W         = 32;
	localparam int ORDER_W        = 4;
	localparam int CFG_W          = 5;
	localparam int RESULT_LIMIT   = 16;
	localparam int MAX_ORDERS_DEF = 16;
	localparam int ORDERS_RESET   = 16;

	localparam logic [PROB_W-1:0] P_ONE = PROB_W'(65536);
	localparam logic [COEF_W-1:0] C_ONE = 32'h8000_0000;
	localparam logic [COEF_W-1:0] C_ZERO = '0;

	// Snapshot hand-over from the coefficient chain to the readout chain
	typedef struct packed {
		logic             load;
		logic [CFG_W-1:0] count;
	} edc_load_t;

endpackage

/* hw/rtl/error_count_distribution.sv */
// Error count distribution: Poisson-binomial coefficient chain with readout.
// Throughput one item per cycle while item_ready is high; each cell's single multiply sets the cycle.
// A last item gives its first coefficient in the cycle after acceptance, then one
// per cycle while result_ready is high; it waits while an earlier readout still holds
// coefficients other than a final one taken in that same cycle.
// Reset: coefficient 0 is 1.0, the others zero, orders_q is 16.
module error_count_distribution #(
	parameter int MAX_ORDERS = edc_pkg::MAX_ORDERS_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cfg_wen,
	input  logic [edc_pkg::CFG_W-1:0]   cfg_wdata,
	input  logic                        item_valid,
	output logic                        item_ready,
	input  logic [edc_pkg::PROB_W-1:0]  error_probability,
	input  logic                        last_error,
	output logic                        result_valid,
	input  logic                        result_ready,
	output logic [edc_pkg::COEF_W-1:0]  coefficient,
	output logic [edc_pkg::ORDER_W-1:0] order,
	output logic                        last_coefficient
);
	import edc_pkg::*;

	localparam int RD_DEPTH = (MAX_ORDERS < RESULT_LIMIT) ? MAX_ORDERS : RESULT_LIMIT;

	logic [CFG_W-1:0]                  orders_q;
	logic [CFG_W-1:0]                  n_clamped;
	logic [PROB_W-1:0]                 p_sat;
	logic                              accept;
	logic                              rd_free;
	logic [MAX_ORDERS-1:0][COEF_W-1:0] coef;
	logic [MAX_ORDERS-1:0][COEF_W-1:0] upd;
	logic [RD_DEPTH-1:0][COEF_W-1:0]   snap;
	edc_load_t                         ld;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			orders_q <= CFG_W'(ORDERS_RESET);
		end else if (cfg_wen) begin
			orders_q <= cfg_wdata;
		end
	end

	always_comb begin
		p_sat = (error_probability > P_ONE) ? P_ONE : error_probability;
		priority if (orders_q == '0) begin
			n_clamped = CFG_W'(1);
		end else if (orders_q > CFG_W'(RD_DEPTH)) begin
			n_clamped = CFG_W'(RD_DEPTH);
		end else begin
			n_clamped = orders_q;
		end
	end

	// Hold a last item until the readout chain can take a fresh snapshot
	assign item_ready = !last_error || rd_free;
	assign accept     = item_valid && item_ready;

	assign ld.load  = accept && last_error;
	assign ld.count = n_clamped;

	for (genvar i = 0; i < MAX_ORDERS; i++) begin : g_cell
		edc_cell #(
			.RESET_VAL((i == 0) ? C_ONE : C_ZERO)
		) u_cell (
			.clk   (clk),
			.arst_n(arst_n),
			.step  (accept),
			.clear (last_error),
			.p     (p_sat),
			.below ((i == 0) ? C_ZERO : coef[(i + MAX_ORDERS - 1) % MAX_ORDERS]),
			.coef  (coef[i]),
			.upd   (upd[i])
		);
	end

	for (genvar i = 0; i < RD_DEPTH; i++) begin : g_snap
		assign snap[i] = upd[i];
	end

	edc_readout #(
		.RD_DEPTH(RD_DEPTH)
	) u_readout (
		.clk             (clk),
		.arst_n          (arst_n),
		.ld              (ld),
		.snap            (snap),
		.result_ready    (result_ready),
		.result_valid    (result_valid),
		.coefficient     (coefficient),
		.order           (order),
		.last_coefficient(last_coefficient),
		.free            (rd_free)
	);

	a_clear_after_last: assert property (@(posedge clk) disable iff (!arst_n)
		accept && last_error |=> coef[0] == C_ONE)
		else $error("coefficient chain not cleared after last transaction");

	a_readout_starts: assert property (@(posedge clk) disable iff (!arst_n)
		accept && last_error |=> result_valid)
		else $error("readout did not start after last transaction");

	a_readout_no_gap: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result_ready && !last_coefficient |=> result_valid)
		else $error("readout run broken before its final coefficient");

	a_coef_bounded: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> coefficient <= C_ONE)
		else $error("coefficient above 1.0");

endmodule

/* hw/rtl/edc_cell.sv */
// One coefficient cell: holds a single Q1.31 coefficient and updates it from
// its own and its lower neighbour's value. Depends on edc_pkg.
module edc_cell #(
	parameter logic [31:0] RESET_VAL = 32'h0
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        step,
	input  logic                        clear,
	input  logic [edc_pkg::PROB_W-1:0]  p,
	input  logic [edc_pkg::COEF_W-1:0]  below,
	output logic [edc_pkg::COEF_W-1:0]  coef,
	output logic [edc_pkg::COEF_W-1:0]  upd
);
	import edc_pkg::*;

	localparam int ACC_W = PROB_W + COEF_W + 2;

	logic [COEF_W-1:0]       coef_q;
	logic signed [COEF_W:0]  diff;
	logic signed [ACC_W-1:0] prod;
	logic signed [ACC_W-1:0] acc;

	// (1-p)*a + p*b equals a*2^16 + p*(b-a): one multiplier per cell
	always_comb begin
		diff = $signed({1'b0, below}) - $signed({1'b0, coef_q});
		prod = $signed({{(ACC_W - PROB_W){1'b0}}, p})
			* $signed({{(ACC_W - COEF_W - 1){diff[COEF_W]}}, diff});
		acc  = $signed({{(ACC_W - COEF_W - PROB_FRAC){1'b0}}, coef_q, {PROB_FRAC{1'b0}}}) + prod;
		upd  = acc[PROB_FRAC +: COEF_W];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			coef_q <= RESET_VAL;
		end else if (step) begin
			coef_q <= clear ? RESET_VAL : upd;
		end
	end

	assign coef = coef_q;

endmodule

/* hw/rtl/edc_readout.sv */
// Readout chain: captures a snapshot of the updated coefficients and shifts
// them out one per transaction towards the output. Depends on edc_pkg.
module edc_readout #(
	parameter int RD_DEPTH = edc_pkg::RESULT_LIMIT
) (
	input  logic                                    clk,
	input  logic                                    arst_n,
	input  edc_pkg::edc_load_t                      ld,
	input  logic [RD_DEPTH-1:0][edc_pkg::COEF_W-1:0] snap,
	input  logic                                    result_ready,
	output logic                                    result_valid,
	output logic [edc_pkg::COEF_W-1:0]              coefficient,
	output logic [edc_pkg::ORDER_W-1:0]             order,
	output logic                                    last_coefficient,
	output logic                                    free
);
	import edc_pkg::*;

	logic [RD_DEPTH-1:0][COEF_W-1:0] shadow_q;
	logic [CFG_W-1:0]                count_q;
	logic [ORDER_W-1:0]              order_q;
	logic                            pop;

	assign result_valid     = (count_q != '0);
	assign last_coefficient = (count_q == CFG_W'(1));
	assign pop              = result_valid && result_ready;
	assign free             = !result_valid || (pop && last_coefficient);
	assign coefficient      = shadow_q[0];
	assign order            = order_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			order_q <= '0;
		end else if (ld.load) begin
			count_q <= ld.count;
			order_q <= '0;
		end else if (pop) begin
			count_q <= count_q - CFG_W'(1);
			order_q <= order_q + ORDER_W'(1);
		end
	end

	// Advance each shadow cell from its upper neighbour
	always_ff @(posedge clk) begin
		for (int i = 0; i < RD_DEPTH; i++) begin
			if (ld.load) begin
				shadow_q[i] <= snap[i];
			end else if (pop) begin
				shadow_q[i] <= (i + 1 < RD_DEPTH) ? shadow_q[(i + 1) % RD_DEPTH] : C_ZERO;
			end
		end
	end

endmodule

/* dv/tb.sv */
// Self-checking testbench for error_count_distribution.
// Depends on edc_pkg and the error_count_distribution RTL; nothing else.
// Directed table first, then random error models checked against a local predictor.
module tb;
	import edc_pkg::*;

	localparam int N_CELLS      = MAX_ORDERS_DEF;
	localparam int HOLD_CYCLES  = 200;
	localparam int STALL_LIMIT  = 3000;
	localparam int DRAIN_CYCLES = 6;
	localparam int PHASE_ITEMS  = 50;
	localparam int N_PHASES     = 8;
	localparam int N_ROWS       = 16;

	localparam logic [COEF_W-1:0] C_HALF = 32'h4000_0000;

	typedef struct packed {
		logic [COEF_W-1:0]  coef;
		logic [ORDER_W-1:0] ord;
		logic               last;
	} coef_txn_t;

	typedef struct packed {
		logic [PROB_W-1:0] prob;
		logic              last;
		logic              typed;
		logic [COEF_W-1:0] c0;
		logic [COEF_W-1:0] c1;
	} prob_row_t;

	// Typed rows start from a clear polynomial; their higher coefficients are zero
	localparam prob_row_t DIRECTED_ROWS [N_ROWS] = '{
		'{17'd0,      1'b1, 1'b1, C_ONE,  C_ZERO},
		'{P_ONE,      1'b1, 1'b1, C_ZERO, C_ONE},
		'{17'h1FFFF,  1'b1, 1'b1, C_ZERO, C_ONE},
		'{17'd32768,  1'b1, 1'b1, C_HALF, C_HALF},
		'{17'd65537,  1'b0, 1'b0, C_ZERO, C_ZERO},
		'{P_ONE,      1'b0, 1'b0, C_ZERO, C_ZERO},
		'{P_ONE,      1'b1, 1'b0, C_ZERO, C_ZERO},
		'{17'd1,      1'b0, 1'b0, C_ZERO, C_ZERO},
		'{17'd65535,  1'b0, 1'b0, C_ZERO, C_ZERO},
		'{17'h0AAAA,  1'b0, 1'b0, C_ZERO, C_ZERO},
		'{17'h15555,  1'b0, 1'b0, C_ZERO, C_ZERO},
		'{17'h0FFFF,  1'b1, 1'b0, C_ZERO, C_ZERO},
		'{17'd32768,  1'b0, 1'b0, C_ZERO, C_ZERO},
		'{17'd32768,  1'b0, 1'b0, C_ZERO, C_ZERO},
		'{17'd32768,  1'b0, 1'b0, C_ZERO, C_ZERO},
		'{17'd32768,  1'b1, 1'b0, C_ZERO, C_ZERO}
	};

	logic                clk;
	logic                arst_n;
	logic                cfg_wen;
	logic [CFG_W-1:0]    cfg_wdata;
	logic                item_valid;
	logic                item_ready;
	logic [PROB_W-1:0]   error_probability;
	logic                last_error;
	logic                result_valid;
	logic                result_ready;
	logic [COEF_W-1:0]   coefficient;
	logic [ORDER_W-1:0]  order;
	logic                last_coefficient;

	// Typed expectation travelling with the offered item
	logic                row_typed;
	logic [COEF_W-1:0]   row_c0;
	logic [COEF_W-1:0]   row_c1;

	logic [COEF_W-1:0]   dist_model [N_CELLS];
	logic [CFG_W-1:0]    orders_model;
	coef_txn_t           pending_coefs [$];
	int                  accepted_items;
	int                  quiet_cycles;
	int                  mismatches;
	bit                  steady;
	bit                  hold_req;

	error_count_distribution i_dut (
		.clk               (clk),
		.arst_n            (arst_n),
		.cfg_wen           (cfg_wen),
		.cfg_wdata         (cfg_wdata),
		.item_valid        (item_valid),
		.item_ready        (item_ready),
		.error_probability (error_probability),
		.last_error        (last_error),
		.result_valid      (result_valid),
		.result_ready      (result_ready),
		.coefficient       (coefficient),
		.order             (order),
		.last_coefficient  (last_coefficient)
	);

	initial clk = 1'b0;
	always #5 clk = ~clk;

	function automatic void clear_distribution();
		int i;
		for (i = 0; i < N_CELLS; i++) begin
			dist_model[i] = C_ZERO;
		end
		dist_model[0] = C_ONE;
	endfunction

	// Fold one error mechanism into the distribution; read out on the last one
	function automatic void fold_probability(input logic [PROB_W-1:0] prob_in,
			input logic is_last, input logic typed, input logic [COEF_W-1:0] c0,
			input logic [COEF_W-1:0] c1);
		logic [PROB_W-1:0] p;
		logic [PROB_W-1:0] q;
		logic [63:0]       acc;
		coef_txn_t         r;
		int                i;
		int                n;
		p = (prob_in > P_ONE) ? P_ONE : prob_in;
		q = P_ONE - p;
		// top down, so the lower neighbour is still the old value
		for (i = N_CELLS - 1; i >= 1; i--) begin
			acc = 64'(q) * 64'(dist_model[i]) + 64'(p) * 64'(dist_model[i-1]);
			dist_model[i] = acc[PROB_FRAC +: COEF_W];
		end
		acc = 64'(q) * 64'(dist_model[0]);
		dist_model[0] = acc[PROB_FRAC +: COEF_W];
		if (!is_last)
			return;
		n = int'(orders_model);
		if (n < 1)
			n = 1;
		if (n > N_CELLS)
			n = N_CELLS;
		if (n > RESULT_LIMIT)
			n = RESULT_LIMIT;
		for (i = 0; i < n; i++) begin
			if (typed)
				r.coef = (i == 0) ? c0 : (i == 1) ? c1 : C_ZERO;
			else
				r.coef = dist_model[i];
			r.ord  = ORDER_W'(i);
			r.last = (i == n - 1);
			pending_coefs.push_back(r);
		end
		clear_distribution();
	endfunction

	function automatic void check_coefficient();
		coef_txn_t want;
		if (pending_coefs.size() == 0) begin
			$display("%0t: unexpected coefficient %h order %0d", $time, coefficient, order);
			mismatches++;
			return;
		end
		want = pending_coefs.pop_front();
		if (coefficient !== want.coef) begin
			$display("%0t: coefficient expected %h actual %h", $time, want.coef, coefficient);
			mismatches++;
		end
		if (order !== want.ord) begin
			$display("%0t: order expected %0d actual %0d", $time, want.ord, order);
			mismatches++;
		end
		if (last_coefficient !== want.last) begin
			$display("%0t: last_coefficient expected %b actual %b", $time, want.last,
				last_coefficient);
			mismatches++;
		end
	endfunction

	// Sample both channels and the register write on the rising edge
	always @(posedge clk) begin
		if (arst_n) begin
			if ((result_valid && result_ready) || (item_valid && item_ready))
				quiet_cycles = 0;
			else
				quiet_cycles++;
			if (result_valid && result_ready)
				check_coefficient();
			if (item_valid && item_ready) begin
				fold_probability(error_probability, last_error, row_typed, row_c0, row_c1);
				accepted_items++;
			end
			if (cfg_wen)
				orders_model = cfg_wdata;
		end
	end

	initial begin
		wait (quiet_cycles >= STALL_LIMIT);
		$display("FAIL error_count_distribution");
		$finish;
	end

	// Receiver: random back-pressure, plus one long hold-off on request
	initial begin
		result_ready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_req) begin
				hold_req = 1'b0;
				result_ready <= 1'b0;
				repeat (HOLD_CYCLES) @(negedge clk);
			end else begin
				result_ready <= steady || ($urandom_range(99) >= 29);
			end
		end
	end

	task automatic send_prob(input logic [PROB_W-1:0] p, input logic l, input logic typed,
			input logic [COEF_W-1:0] c0, input logic [COEF_W-1:0] c1);
		int taken;
		taken = accepted_items;
		while (!steady && $urandom_range(99) < 29) begin
			item_valid <= 1'b0;
			@(negedge clk);
		end
		item_valid        <= 1'b1;
		error_probability <= p;
		last_error        <= l;
		row_typed         <= typed;
		row_c0            <= c0;
		row_c1            <= c1;
		do @(negedge clk); while (accepted_items == taken);
	endtask

	task automatic wait_idle();
		item_valid <= 1'b0;
		do @(negedge clk); while (pending_coefs.size() != 0);
		repeat (DRAIN_CYCLES) @(negedge clk);
	endtask

	task automatic write_orders(input logic [CFG_W-1:0] value);
		cfg_wen   <= 1'b1;
		cfg_wdata <= value;
		@(negedge clk);
		cfg_wen   <= 1'b0;
	endtask

	function automatic logic [PROB_W-1:0] pick_probability();
		case ($urandom_range(9))
			0:       return '0;
			1:       return P_ONE;
			2:       return PROB_W'($urandom_range(131071, 65537));
			3:       return PROB_W'($urandom_range(255));
			4:       return P_ONE - PROB_W'($urandom_range(255));
			default: return PROB_W'($urandom_range(65536));
		endcase
	endfunction

	// Random error models: mostly short, now and then longer than the polynomial
	task automatic run_models(input int items);
		int sent;
		int len;
		int k;
		sent = 0;
		while (sent < items) begin
			if ($urandom_range(9) == 0)
				len = $urandom_range(40, 17);
			else
				len = $urandom_range(12, 1);
			for (k = 0; k < len; k++) begin
				send_prob(pick_probability(), k == len - 1, 1'b0, C_ZERO, C_ZERO);
			end
			sent += len;
		end
	endtask

	initial begin
		logic [CFG_W-1:0] phase_orders [N_PHASES];
		int               ph;
		int               r;
		phase_orders = '{5'd1, 5'd0, 5'd31, 5'd17, 5'd5, 5'd16, 5'd9, 5'd2};
		phase_orders[N_PHASES-1] = CFG_W'($urandom_range(31));
		arst_n            = 1'b0;
		cfg_wen           = 1'b0;
		cfg_wdata         = '0;
		item_valid        = 1'b0;
		error_probability = '0;
		last_error        = 1'b0;
		row_typed         = 1'b0;
		row_c0            = C_ZERO;
		row_c1            = C_ZERO;
		accepted_items    = 0;
		quiet_cycles      = 0;
		mismatches        = 0;
		steady            = 1'b0;
		hold_req          = 1'b0;
		orders_model      = CFG_W'(ORDERS_RESET);
		clear_distribution();
		repeat (9) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		for (r = 0; r < N_ROWS; r++) begin
			send_prob(DIRECTED_ROWS[r].prob, DIRECTED_ROWS[r].last, DIRECTED_ROWS[r].typed,
				DIRECTED_ROWS[r].c0, DIRECTED_ROWS[r].c1);
		end

		for (ph = 0; ph < N_PHASES; ph++) begin
			wait_idle();
			write_orders(phase_orders[ph]);
			steady = (ph == 3);
			// let the output back up while items keep coming
			if (ph == 5)
				hold_req = 1'b1;
			run_models(PHASE_ITEMS);
		end
		steady = 1'b0;

		wait_idle();
		if (mismatches == 0)
			$display("PASS error_count_distribution");
		else
			$display("FAIL error_count_distribution");
		$finish;
	end

endmodule

/* error_count_distribution.f */
hw/rtl/edc_pkg.sv
hw/rtl/edc_cell.sv
hw/rtl/edc_readout.sv
hw/rtl/error_count_distribution.sv
dv/tb.sv
